### rtl/detection_anchor_generator_assert.svh
// ----------------------------------------------------------------------------
// detection_anchor_generator assertion macros
// Shared assertion forms for the anchor generator RTL.
// ----------------------------------------------------------------------------
`ifndef DETECTION_ANCHOR_GENERATOR_ASSERT_SVH
`define DETECTION_ANCHOR_GENERATOR_ASSERT_SVH

// clocked on clk, quiet while rst is high
`define DAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked on clk, also checked during reset
`define DAG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dag_pkg.sv
// ----------------------------------------------------------------------------
// dag_pkg
// Types and constants shared by the anchor generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dag_pkg;

  localparam int MAX_SCALES_DEF = 4;
  localparam int NUM_SCALE_REGS = 4;

  localparam int RATIO_W  = 16;
  localparam int BASE_W   = 11;
  localparam int NSC_W    = 3;
  localparam int SCALE_W  = 16;
  localparam int CENTER_W = 10;
  localparam int SIZE_W   = 30;
  localparam int DIM_W_W  = 16;
  localparam int DIM_H_W  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [BASE_W-1:0]  BASE_SIDE_RST  = 11'd16;
  localparam logic [NSC_W-1:0]   NUM_SCALES_RST = 3'd3;
  localparam logic [SCALE_W-1:0] SCALE0_RST     = 16'd2048;
  localparam logic [SCALE_W-1:0] SCALE1_RST     = 16'd4096;
  localparam logic [SCALE_W-1:0] SCALE2_RST     = 16'd8192;
  localparam logic [SCALE_W-1:0] SCALE3_RST     = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SIDE  = 3'd0,
    REG_NUM_SCALES = 3'd1,
    REG_SCALE_0    = 3'd2,
    REG_SCALE_1    = 3'd3,
    REG_SCALE_2    = 3'd4,
    REG_SCALE_3    = 3'd5
  } cfg_reg_t;

  // integer width and height of the ratio-adjusted base anchor
  typedef struct packed {
    logic [DIM_W_W-1:0] w;
    logic [DIM_H_W-1:0] h;
  } anchor_dim_t;

endpackage

`default_nettype wire

### rtl/dag_front.sv
// ----------------------------------------------------------------------------
// dag_front
// Ratio pipeline: area / ratio (6 stages), square root (3 stages), w and h.
// ----------------------------------------------------------------------------
`default_nettype none

module dag_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [dag_pkg::RATIO_W-1:0]   ratio,
  input  wire logic [dag_pkg::BASE_W-1:0]    base_side,
  output logic                               dim_valid,
  input  wire logic                          dim_ready,
  output dag_pkg::anchor_dim_t               dim
);

  `include "detection_anchor_generator_assert.svh"

  localparam int NDIV = 6;
  localparam int NSQ  = 3;
  localparam int NST  = NDIV + NSQ + 1;

  typedef struct packed {
    logic [15:0] d;
    logic [25:0] rem;
    logic [47:0] x;
    logic [47:0] acc;
  } stg_t;

  // restoring division, eight quotient bits
  function automatic stg_t div8(stg_t s);
    stg_t o;
    logic [16:0] t;
    o = s;
    for (int i = 0; i < 8; i++) begin
      t = {o.rem[15:0], o.x[47]};
      o.x = {o.x[46:0], 1'b0};
      if (t >= {1'b0, o.d}) begin
        o.rem = 26'(t - {1'b0, o.d});
        o.acc = {o.acc[46:0], 1'b1};
      end else begin
        o.rem = 26'(t);
        o.acc = {o.acc[46:0], 1'b0};
      end
    end
    return o;
  endfunction

  // digit-by-digit square root, eight root bits
  function automatic stg_t sqrt8(stg_t s);
    stg_t o;
    logic [27:0] t;
    logic [27:0] trial;
    o = s;
    for (int i = 0; i < 8; i++) begin
      t = {o.rem, o.x[47:46]};
      trial = {2'b00, o.acc[23:0], 2'b01};
      o.x = {o.x[45:0], 2'b00};
      if (t >= trial) begin
        o.rem = 26'(t - trial);
        o.acc = {o.acc[46:0], 1'b1};
      end else begin
        o.rem = 26'(t);
        o.acc = {o.acc[46:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic stg_t seed(stg_t s);
    stg_t o;
    o.d = s.d;
    o.rem = '0;
    o.x = s.acc;
    o.acc = '0;
    return o;
  endfunction

  stg_t           st  [NST];
  stg_t           nxt [NST];
  logic [NST-1:0] vld;
  logic           wv;
  logic [15:0]    w;
  logic [15:0]    wd;
  logic           adv;
  logic [21:0]    area;
  logic [15:0]    dfix;
  logic [24:0]    rsum;
  logic [31:0]    hp;
  logic [32:0]    hs;

  assign adv  = !wv || dim_ready;
  assign full = !adv;

  assign area = {11'b0, base_side} * {11'b0, base_side};
  assign dfix = (ratio == '0) ? 16'd1 : ratio;

  assign nxt[0] = {dfix, 26'b0, {2'b00, area, 24'b0}, 48'b0};

  for (genvar j = 1; j < NST; j++) begin : g_stage
    if (j <= NDIV) begin : g_div
      assign nxt[j] = div8(st[j-1]);
    end else if (j == NDIV + 1) begin : g_sq0
      assign nxt[j] = sqrt8(seed(st[j-1]));
    end else begin : g_sq
      assign nxt[j] = sqrt8(st[j-1]);
    end
  end

  assign rsum = {1'b0, st[NST-1].acc[23:0]} + 25'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      wv  <= 1'b0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], push};
      wv  <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NST; j++) begin
        st[j] <= nxt[j];
      end
      w  <= rsum[23:8];
      wd <= st[NST-1].d;
    end
  end

  assign hp = {16'b0, w} * {16'b0, wd};
  assign hs = {1'b0, hp} + 33'd128;

  assign dim_valid = wv;
  assign dim.w     = w;
  assign dim.h     = hs[31:8];

  `DAG_ASSERT(a_stall_holds, (wv && !dim_ready) |=> wv, "front lost a word while stalled")

endmodule

`default_nettype wire

### rtl/dag_queue.sv
// ----------------------------------------------------------------------------
// dag_queue
// Short queue between the ratio pipeline and the anchor emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module dag_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  dag_pkg::anchor_dim_t      wdata,
  input  wire logic                 pop,
  output logic                      empty,
  output dag_pkg::anchor_dim_t      rdata
);

  `include "detection_anchor_generator_assert.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dag_pkg::anchor_dim_t mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

  `DAG_ASSERT(a_cnt_bound, cnt <= CW'(DEPTH), "queue count beyond depth")
  `DAG_ASSERT(a_cnt_inc, (do_push && !do_pop) |=> cnt == $past(cnt) + 1'b1, "queue count slip")
  `DAG_ASSERT_ALWAYS(a_rst_empty, rst |=> empty, "queue not empty after reset")

endmodule

`default_nettype wire

### rtl/dag_back.sv
// ----------------------------------------------------------------------------
// dag_back
// Anchor emitter: one scaled anchor per cycle from the queue head, while the result is not held.
// ----------------------------------------------------------------------------
`default_nettype none

module dag_back #(
  parameter int MAX_SCALES = dag_pkg::MAX_SCALES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  dag_pkg::anchor_dim_t               head,
  output logic                               head_pop,
  input  wire logic [dag_pkg::BASE_W-1:0]    base_side,
  input  wire logic [dag_pkg::NSC_W-1:0]     num_scales,
  input  wire logic [dag_pkg::SCALE_W-1:0]   scale [dag_pkg::NUM_SCALE_REGS],
  output logic                               empty,
  input  wire logic                          pop,
  output logic [dag_pkg::CENTER_W-1:0]       center_half,
  output logic [dag_pkg::SIZE_W-1:0]         anchor_w,
  output logic [dag_pkg::SIZE_W-1:0]         anchor_h,
  output logic                               last
);

  `include "detection_anchor_generator_assert.svh"

  localparam int KW = (MAX_SCALES > 1) ? $clog2(MAX_SCALES) : 1;
  localparam int NW = $clog2(MAX_SCALES + 1);

  logic          ov;
  logic [KW-1:0] k;
  logic [NW-1:0] n;
  logic          load;
  logic          emit;
  logic          is_last;
  logic [15:0]   sc;
  logic [31:0]   pw;
  logic [39:0]   ph;
  logic [dag_pkg::BASE_W-1:0]   bm1;
  logic [dag_pkg::CENTER_W-1:0] center;

  assign n = (num_scales > dag_pkg::NSC_W'(MAX_SCALES)) ? NW'(MAX_SCALES)
                                                         : NW'(num_scales);
  assign load    = !ov || pop;
  assign emit    = head_valid && load && (n != '0);
  assign is_last = (NW'(k) + 1'b1) == n;
  // zero scale count: drop the word without output
  assign head_pop = head_valid && load && ((n == '0) || is_last);

  assign sc = scale[2'(k)];
  assign pw = {16'b0, head.w} * {16'b0, sc};
  assign ph = {16'b0, head.h} * {24'b0, sc};

  assign bm1 = base_side - 1'b1;
  always_comb begin
    if (base_side == '0) begin
      center = '0;
    end else if (bm1[10]) begin
      center = '1;
    end else begin
      center = bm1[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      k  <= '0;
    end else begin
      if (load) begin
        ov <= emit;
      end
      if (emit) begin
        k <= is_last ? '0 : k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      center_half <= center;
      anchor_w    <= (pw[31:30] != '0) ? '1 : pw[29:0];
      anchor_h    <= (ph[39:30] != '0) ? '1 : ph[29:0];
      last        <= is_last;
    end
  end

  assign empty = !ov;

  `DAG_ASSERT(a_k_wrap, (emit && is_last) |=> k == '0, "scale index did not wrap")
  `DAG_ASSERT(a_pop_held, (ov && !pop) |=> ov && $stable(anchor_w), "result changed while held")

endmodule

`default_nettype wire

### rtl/detection_anchor_generator.sv
// ----------------------------------------------------------------------------
// detection_anchor_generator
// Anchor boxes for one aspect ratio over up to MAX_SCALES scales.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Moves
// input     push / full               ratio
// result    pop / empty               center_half, anchor_w, anchor_h, last
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The front takes one ratio a cycle while full is low into an 11-stage
// pipeline (input stage, six divide stages, three square root stages, one
// rounding stage); each result then passes through the queue to the emitter.
// The emitter gives one anchor a cycle while the queue holds a ratio and the
// result is not held: a ratio yields n anchors, n the scale count in use,
// one scale at a time on the one multiplier pair in the emitter.
// Reset loads the register defaults; there is no clearing pass.
// Either side may stall; a 4-word queue lets the front run on meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module detection_anchor_generator #(
  parameter int MAX_SCALES = dag_pkg::MAX_SCALES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [dag_pkg::RATIO_W-1:0]      ratio,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [dag_pkg::CENTER_W-1:0]          center_half,
  output logic [dag_pkg::SIZE_W-1:0]            anchor_w,
  output logic [dag_pkg::SIZE_W-1:0]            anchor_h,
  output logic                                  last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dag_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [dag_pkg::BASE_W-1:0]  base_side;
  logic [dag_pkg::NSC_W-1:0]   num_scales;
  logic [dag_pkg::SCALE_W-1:0] scale [dag_pkg::NUM_SCALE_REGS];

  logic                 dim_valid;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  dag_pkg::anchor_dim_t dim;
  dag_pkg::anchor_dim_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_side  <= dag_pkg::BASE_SIDE_RST;
      num_scales <= dag_pkg::NUM_SCALES_RST;
      scale[0]   <= dag_pkg::SCALE0_RST;
      scale[1]   <= dag_pkg::SCALE1_RST;
      scale[2]   <= dag_pkg::SCALE2_RST;
      scale[3]   <= dag_pkg::SCALE3_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dag_pkg::REG_BASE_SIDE:  base_side  <= cfg_data[dag_pkg::BASE_W-1:0];
        dag_pkg::REG_NUM_SCALES: num_scales <= cfg_data[dag_pkg::NSC_W-1:0];
        dag_pkg::REG_SCALE_0:    scale[0]   <= cfg_data;
        dag_pkg::REG_SCALE_1:    scale[1]   <= cfg_data;
        dag_pkg::REG_SCALE_2:    scale[2]   <= cfg_data;
        dag_pkg::REG_SCALE_3:    scale[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  dag_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .ratio     (ratio),
    .base_side (base_side),
    .dim_valid (dim_valid),
    .dim_ready (!q_full),
    .dim       (dim)
  );

  dag_queue #(.DEPTH(4)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (dim_valid),
    .full  (q_full),
    .wdata (dim),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_head)
  );

  dag_back #(.MAX_SCALES(MAX_SCALES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!q_empty),
    .head        (q_head),
    .head_pop    (q_pop),
    .base_side   (base_side),
    .num_scales  (num_scales),
    .scale       (scale),
    .empty       (empty),
    .pop         (pop),
    .center_half (center_half),
    .anchor_w    (anchor_w),
    .anchor_h    (anchor_h),
    .last        (last)
  );

endmodule

`default_nettype wire
